FILE: src/sle_pkg.sv
// ----------------------------------------------------------------------------
// Scancode line editor package
// Word types, request codes, key constants and the set-1 US key table.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int LINE_CAPACITY = 128;
  localparam int ADDR_W = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;
  localparam int CNT_W = $clog2(LINE_CAPACITY + 1);
  localparam int CMP_W = 16;

  localparam logic [7:0] SC_SCROLL_LOCK = 8'd70;
  localparam logic [7:0] SC_DELETE = 8'd83;
  localparam logic [6:0] CH_BACKSPACE = 7'd8;
  localparam logic [6:0] CH_ENTER = 7'd10;

  typedef enum logic [1:0] {
    REQ_SCAN  = 2'd0,
    REQ_START = 2'd1,
    REQ_TAKE  = 2'd2,
    REQ_READ  = 2'd3
  } req_t;

  typedef struct packed {
    req_t       req_type;
    logic [7:0] scancode;
    logic [6:0] read_index;
  } in_word_t;

  typedef struct packed {
    logic        echo_valid;
    logic [6:0]  echo_char;
    logic        line_done;
    logic [7:0]  line_length;
    logic        key_valid;
    logic [14:0] key_code;
    logic [6:0]  read_char;
    logic        reboot_request;
  } out_word_t;

  function automatic logic [6:0] key_char(input logic [6:0] code);
    logic [6:0] c;
    c = 7'h00;
    unique case (code)
      7'd1:  c = 7'h1b;
      7'd2:  c = 7'h31;
      7'd3:  c = 7'h32;
      7'd4:  c = 7'h33;
      7'd5:  c = 7'h34;
      7'd6:  c = 7'h35;
      7'd7:  c = 7'h36;
      7'd8:  c = 7'h37;
      7'd9:  c = 7'h38;
      7'd10: c = 7'h39;
      7'd11: c = 7'h30;
      7'd12: c = 7'h2d;
      7'd13: c = 7'h3d;
      7'd14: c = 7'h08;
      7'd15: c = 7'h09;
      7'd16: c = 7'h71;
      7'd17: c = 7'h77;
      7'd18: c = 7'h65;
      7'd19: c = 7'h72;
      7'd20: c = 7'h74;
      7'd21: c = 7'h79;
      7'd22: c = 7'h75;
      7'd23: c = 7'h69;
      7'd24: c = 7'h6f;
      7'd25: c = 7'h70;
      7'd26: c = 7'h5b;
      7'd27: c = 7'h5d;
      7'd28: c = 7'h0a;
      7'd30: c = 7'h61;
      7'd31: c = 7'h73;
      7'd32: c = 7'h64;
      7'd33: c = 7'h66;
      7'd34: c = 7'h67;
      7'd35: c = 7'h68;
      7'd36: c = 7'h6a;
      7'd37: c = 7'h6b;
      7'd38: c = 7'h6c;
      7'd39: c = 7'h3b;
      7'd40: c = 7'h27;
      7'd41: c = 7'h60;
      7'd43: c = 7'h5c;
      7'd44: c = 7'h7a;
      7'd45: c = 7'h78;
      7'd46: c = 7'h63;
      7'd47: c = 7'h76;
      7'd48: c = 7'h62;
      7'd49: c = 7'h6e;
      7'd50: c = 7'h6d;
      7'd51: c = 7'h2c;
      7'd52: c = 7'h2e;
      7'd53: c = 7'h2f;
      7'd55: c = 7'h2a;
      7'd57: c = 7'h20;
      7'd74: c = 7'h2d;
      7'd78: c = 7'h2b;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

endpackage

FILE: src/sle_line_ram.sv
// ----------------------------------------------------------------------------
// Line buffer RAM
// Single write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sle_line_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 7,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/scancode_line_editor_core.sv
// ----------------------------------------------------------------------------
// Scancode line editor core
// A result word is registered at input accept and appears in the next cycle.
// Throughput: one word per cycle unless the result stalls; the scalar state
// updates at accept and the line buffer RAM is written and read at accept.
// Reset clears the line count, key, sequence counter, echo enable (to 1) and
// output valid; the line buffer RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module scancode_line_editor_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  sle_pkg::in_word_t  in_word,
  output logic              out_valid,
  input  logic              out_ready,
  output sle_pkg::out_word_t out_word,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data
);

  logic echo_enable;
  logic [sle_pkg::CNT_W-1:0] char_count, char_count_next;
  logic input_complete, input_complete_next;
  logic [14:0] last_key, last_key_next;
  logic [1:0] sequence_count, sequence_count_next;

  sle_pkg::out_word_t out_reg, out_reg_next;
  logic read_hit, read_hit_next;
  logic [6:0] rd_data;

  logic accept;
  logic press;
  logic quiet;
  logic append;
  logic [6:0] c;

  assign cfg_ready = 1'b1;
  assign in_ready = !out_valid || out_ready;
  assign accept = in_valid && in_ready;
  assign press = !in_word.scancode[7];
  assign c = sle_pkg::key_char(in_word.scancode[6:0]);

  always_comb begin
    char_count_next = char_count;
    input_complete_next = input_complete;
    last_key_next = last_key;
    sequence_count_next = sequence_count;
    out_reg_next = '0;
    read_hit_next = 1'b0;
    quiet = 1'b0;
    append = 1'b0;
    unique case (in_word.req_type)
      sle_pkg::REQ_SCAN: begin
        if (press) begin
          last_key_next = {in_word.scancode[6:0], 1'b0, c};
          out_reg_next.echo_char = c;
          if (c == sle_pkg::CH_ENTER) begin
            input_complete_next = 1'b1;
          end else if (c == sle_pkg::CH_BACKSPACE) begin
            if (char_count != '0) begin
              char_count_next = char_count - 1'b1;
            end else begin
              quiet = 1'b1;
            end
          end else if (char_count < sle_pkg::CNT_W'(sle_pkg::LINE_CAPACITY)
                       && !input_complete) begin
            if (c != 7'd0) begin
              append = 1'b1;
              char_count_next = char_count + 1'b1;
            end
          end else begin
            input_complete_next = 1'b1;
          end
          out_reg_next.echo_valid = echo_enable && !quiet && (c != 7'd0);
          priority if (in_word.scancode == sle_pkg::SC_SCROLL_LOCK) begin
            if (sequence_count < 2'd2) begin
              sequence_count_next = sequence_count + 2'd1;
            end
          end else if (sequence_count == 2'd2
                       && in_word.scancode == sle_pkg::SC_DELETE) begin
            out_reg_next.reboot_request = 1'b1;
            sequence_count_next = 2'd0;
          end else begin
            sequence_count_next = 2'd0;
          end
        end
      end
      sle_pkg::REQ_START: begin
        input_complete_next = 1'b0;
        char_count_next = '0;
      end
      sle_pkg::REQ_TAKE: begin
        out_reg_next.key_valid = (last_key != 15'd0);
        out_reg_next.key_code = last_key;
        last_key_next = 15'd0;
      end
      sle_pkg::REQ_READ: begin
        read_hit_next = sle_pkg::CMP_W'(in_word.read_index)
                        < sle_pkg::CMP_W'(char_count);
      end
      default: begin
        read_hit_next = 1'b0;
      end
    endcase
    out_reg_next.line_done = input_complete_next;
    out_reg_next.line_length = 8'(char_count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      echo_enable <= 1'b1;
      char_count <= '0;
      input_complete <= 1'b1;
      last_key <= 15'd0;
      sequence_count <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        echo_enable <= cfg_data;
      end
      if (accept) begin
        char_count <= char_count_next;
        input_complete <= input_complete_next;
        last_key <= last_key_next;
        sequence_count <= sequence_count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_reg <= out_reg_next;
      read_hit <= read_hit_next;
    end
  end

  sle_line_ram #(
    .DEPTH(sle_pkg::LINE_CAPACITY),
    .WIDTH(7)
  ) u_line_ram (
    .clk    (clk),
    .wr_en  (accept && append),
    .wr_addr(char_count[sle_pkg::ADDR_W-1:0]),
    .wr_data(c),
    .rd_en  (accept),
    .rd_addr(sle_pkg::ADDR_W'(in_word.read_index)),
    .rd_data(rd_data)
  );

  always_comb begin
    out_word = out_reg;
    out_word.read_char = read_hit ? rd_data : 7'd0;
  end

endmodule

FILE: bench/sle_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scancode line editor checker
// Watches the input, result and configuration channels of the line editor.
// It keeps its own model of the editor state, predicts one result word for
// every accepted input word, and compares each accepted result word field by
// field with the oldest prediction. Failures are counted for the bench top.
// ----------------------------------------------------------------------------
module sle_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  sle_pkg::in_word_t  in_word,
  input  logic               out_valid,
  input  logic               out_ready,
  input  sle_pkg::out_word_t out_word,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic               cfg_data,
  output int                 fail_count,
  output int                 outstanding
);

  localparam logic [6:0] KEY_TABLE [0:79] = '{
    7'h00, 7'h1b, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h30, 7'h2d, 7'h3d, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
    7'h74, 7'h79, 7'h75, 7'h69, 7'h6f, 7'h70, 7'h5b, 7'h5d, 7'h0a, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6a, 7'h6b, 7'h6c, 7'h3b,
    7'h27, 7'h60, 7'h00, 7'h5c, 7'h7a, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6e,
    7'h6d, 7'h2c, 7'h2e, 7'h2f, 7'h00, 7'h2a, 7'h00, 7'h20, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h2d, 7'h00, 7'h00, 7'h00, 7'h2b, 7'h00
  };

  logic [6:0]         line_store [sle_pkg::LINE_CAPACITY];
  int                 char_count = 0;
  bit                 line_closed = 1'b1;
  logic [14:0]        held_key = '0;
  int                 scroll_run = 0;
  bit                 echo_on = 1'b1;
  sle_pkg::out_word_t expected_words [$];
  sle_pkg::out_word_t oldest;
  int                 miss = 0;

  function automatic sle_pkg::out_word_t edit_step(input sle_pkg::in_word_t w);
    sle_pkg::out_word_t r;
    logic [6:0]         c;
    bit                 quiet;
    r = '0;
    case (w.req_type)
      sle_pkg::REQ_SCAN: if (!w.scancode[7]) begin
        c = 7'h00;
        if (w.scancode < 8'd80) c = KEY_TABLE[w.scancode[6:0]];
        quiet = 1'b0;
        held_key = {w.scancode[6:0], 1'b0, c};
        r.echo_char = c;
        if (c == sle_pkg::CH_ENTER) begin
          line_closed = 1'b1;
        end else if (c == sle_pkg::CH_BACKSPACE) begin
          if (char_count > 0) char_count--;
          else quiet = 1'b1;
        end else if (char_count < sle_pkg::LINE_CAPACITY && !line_closed) begin
          if (c != 7'h00) begin
            line_store[char_count] = c;
            char_count++;
          end
        end else begin
          line_closed = 1'b1;
        end
        r.echo_valid = echo_on && !quiet && (c != 7'h00);
        if (w.scancode == sle_pkg::SC_SCROLL_LOCK) begin
          if (scroll_run < 2) scroll_run++;
        end else if (scroll_run == 2 && w.scancode == sle_pkg::SC_DELETE) begin
          r.reboot_request = 1'b1;
          scroll_run = 0;
        end else begin
          scroll_run = 0;
        end
      end
      sle_pkg::REQ_START: begin
        line_closed = 1'b0;
        char_count = 0;
      end
      sle_pkg::REQ_TAKE: begin
        r.key_valid = (held_key != '0);
        r.key_code = held_key;
        held_key = '0;
      end
      default: begin
        if (w.read_index < char_count) r.read_char = line_store[w.read_index];
      end
    endcase
    r.line_done = line_closed;
    r.line_length = 8'(char_count);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      char_count = 0;
      line_closed = 1'b1;
      held_key = '0;
      scroll_run = 0;
      echo_on = 1'b1;
      expected_words.delete();
    end else begin
      if (cfg_valid && cfg_ready) echo_on = cfg_data;
      if (in_valid && in_ready) expected_words.push_back(edit_step(in_word));
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          miss++;
          if (miss <= 10) $display("%0t: unexpected result word %p", $time, out_word);
        end else begin
          oldest = expected_words.pop_front();
          if (oldest.echo_valid !== out_word.echo_valid ||
              oldest.echo_char !== out_word.echo_char ||
              oldest.line_done !== out_word.line_done ||
              oldest.line_length !== out_word.line_length ||
              oldest.key_valid !== out_word.key_valid ||
              oldest.key_code !== out_word.key_code ||
              oldest.read_char !== out_word.read_char ||
              oldest.reboot_request !== out_word.reboot_request) begin
            miss++;
            if (miss <= 10) begin
              $display("%0t: result mismatch, expected %p, got %p", $time, oldest, out_word);
            end
          end
        end
      end
    end
    fail_count <= miss;
    outstanding <= expected_words.size();
  end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scancode line editor testbench
// Drives directed and random request words into the line editor core with
// random gaps and result stalls, changes the echo setting between phases,
// and reports the verdict from the failure count of the checker.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [7:0] KC_Q = 8'd16;
  localparam logic [7:0] KC_A = 8'd30;
  localparam logic [7:0] KC_SPACE = 8'd57;
  localparam logic [7:0] KC_BACKSPACE = 8'd14;
  localparam logic [7:0] KC_ENTER = 8'd28;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  sle_pkg::in_word_t  in_word = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  sle_pkg::out_word_t out_word;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_data = 1'b0;
  int                 fail_count;
  int                 outstanding;
  bit                 gaps_on = 1'b1;
  int                 words_sent = 0;

  always #5 clk = ~clk;

  scancode_line_editor_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  sle_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_word    (out_word),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    #5ms;
    $display("[scancode_line_editor_core] ERROR");
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (gaps_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  task automatic put_word(input sle_pkg::req_t req, input logic [7:0] sc,
                          input logic [6:0] idx);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= '{req_type: req, scancode: sc, read_index: idx};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic press(input logic [7:0] sc);
    put_word(sle_pkg::REQ_SCAN, sc, 7'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic set_echo(input logic value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_press();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return KC_BACKSPACE;
    if (r < 12) return KC_ENTER;
    if (r < 22) return 8'($urandom_range(0, 127));
    return 8'($urandom_range(1, 57));
  endfunction

  task automatic line_burst();
    int n;
    int r;
    n = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 20);
    put_word(sle_pkg::REQ_START, 8'($urandom), 7'($urandom));
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        press(pick_press());
      end else if (r < 83) begin
        press({1'b1, 7'($urandom)});
      end else if (r < 95) begin
        put_word(sle_pkg::REQ_READ, 8'($urandom),
                 ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(0, 24)));
      end else begin
        put_word(sle_pkg::REQ_TAKE, 8'($urandom), 7'($urandom));
      end
    end
  endtask

  task automatic fill_line();
    put_word(sle_pkg::REQ_START, 8'($urandom), 7'($urandom));
    repeat ($urandom_range(126, 134)) press(8'($urandom_range(16, 25)));
    put_word(sle_pkg::REQ_READ, 8'($urandom), 7'h7f);
    put_word(sle_pkg::REQ_READ, 8'($urandom), 7'($urandom));
  endtask

  task automatic magic_keys();
    repeat ($urandom_range(1, 3)) press(sle_pkg::SC_SCROLL_LOCK);
    if ($urandom_range(0, 3) == 0) press(pick_press());
    press(sle_pkg::SC_DELETE);
  endtask

  initial begin
    int pick;
    int phase_end;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    press(KC_A);
    put_word(sle_pkg::REQ_TAKE, 8'hff, 7'h7f);
    put_word(sle_pkg::REQ_TAKE, 8'h00, 7'h00);
    put_word(sle_pkg::REQ_START, 8'h00, 7'h00);
    press(KC_BACKSPACE);
    press(8'h00);
    press(8'h7f);
    press(KC_Q);
    press(KC_SPACE);
    press(KC_A);
    press(8'h80);
    press(8'hff);
    press(KC_BACKSPACE);
    put_word(sle_pkg::REQ_READ, 8'h00, 7'd0);
    put_word(sle_pkg::REQ_READ, 8'hff, 7'd1);
    put_word(sle_pkg::REQ_READ, 8'h00, 7'd2);
    put_word(sle_pkg::REQ_READ, 8'h00, 7'h7f);
    repeat (3) press(sle_pkg::SC_SCROLL_LOCK);
    press(sle_pkg::SC_DELETE);
    press(sle_pkg::SC_DELETE);
    press(sle_pkg::SC_SCROLL_LOCK);
    press(KC_A);
    press(sle_pkg::SC_DELETE);
    press(KC_ENTER);
    press(KC_Q);
    put_word(sle_pkg::REQ_TAKE, 8'h00, 7'h00);

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      set_echo((ph < 4) ? ph[0] : 1'($urandom));
      if (ph == 5) gaps_on = 1'b0;
      phase_end = words_sent + 305;
      while (words_sent < phase_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
          fill_line();
        end else if (pick < 55) begin
          line_burst();
        end else if (pick < 70) begin
          magic_keys();
        end else if (pick < 80) begin
          put_word(sle_pkg::REQ_TAKE, 8'($urandom), 7'($urandom));
        end else begin
          repeat ($urandom_range(1, 5)) begin
            put_word(sle_pkg::req_t'($urandom_range(0, 3)), 8'($urandom), 7'($urandom));
          end
        end
      end
    end

    drain();
    repeat (5) @(posedge clk);
    if (fail_count == 0) begin
      $display("[scancode_line_editor_core] OK");
    end else begin
      $display("[scancode_line_editor_core] ERROR");
    end
    $finish;
  end

endmodule
